### rtl/offset_hough_vote_peak_assert.svh
// Assertion macros for the offset Hough vote peak block
`ifndef OFFSET_HOUGH_VOTE_PEAK_ASSERT_SVH
`define OFFSET_HOUGH_VOTE_PEAK_ASSERT_SVH
`ifndef SYNTHESIS
`define OHVP_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define OHVP_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define OHVP_ASSERT_IMP(label, clk, rst_n, a, c)
`define OHVP_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

### rtl/ohvp_pkg.sv
// ----------------------------------------------------------------------------
// ohvp_pkg
// Shared types and constants of the offset Hough vote peak block.
// ----------------------------------------------------------------------------
`default_nettype none
package ohvp_pkg;
    localparam int GRID = 256;
    localparam int CW = 16;
    localparam logic [CW-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic FUNC_VOTE   = 1'b0;
    localparam logic FUNC_REPORT = 1'b1;
    localparam logic [1:0] REG_XLO = 2'd0;
    localparam logic [1:0] REG_YLO = 2'd1;
    localparam logic [1:0] REG_XHI = 2'd2;
    localparam logic [1:0] REG_YHI = 2'd3;
endpackage
`default_nettype wire

### rtl/ohvp_div.sv
// ----------------------------------------------------------------------------
// ohvp_div
// Restoring divider, one quotient bit per cycle, unsigned 42 / 33 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module ohvp_div
    import ohvp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [41:0] num,
    input  wire logic [32:0] den,
    output logic             busy,
    output logic             done,
    output logic [41:0]      quo
);
    logic [41:0] q_reg, q_next;
    logic [33:0] r_reg, r_next;
    logic [32:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [33:0] trial;

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = q_reg;

    // shift in one numerator bit and try subtracting
    always_comb
    begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        trial = {r_reg[32:0], q_reg[41]};
        if (start)
        begin
            q_next = num; r_next = '0; d_next = den;
            cnt_next = 6'd42; busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[40:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[40:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next;
    end
endmodule
`default_nettype wire

### rtl/offset_hough_vote_peak.sv
// ----------------------------------------------------------------------------
// offset_hough_vote_peak
// Offset histogram vote with 3x3 kernel and first-largest peak report.
// ----------------------------------------------------------------------------
// channel | direction | handshake           | payload
// item    | in        | start & !busy       | func, image_x/y, catalog_x/y
// config  | in        | cfg_valid&cfg_ready | cfg_index, cfg_data
// result  | out       | result_valid strobe | peak_bin_x/y, peak_votes, shift_x/y
// A vote makes two passes through one restoring divider, then nine
// read-modify-write beats on the histogram memory. It ends without a
// vote if a range is not positive, an offset is low or a bin lies outside 1..GRID-2.
// A report walks all GRID*GRID cells, one per cycle, clearing each as it
// goes, then two multiply beats, a beat for the y shift and an output
// beat; result_valid rises in the same cycle as busy drops.
// After reset a clearing pass over all GRID*GRID cells runs with busy high.
// The receiver cannot stall; result_valid is high for one cycle.
`default_nettype none
module offset_hough_vote_peak
    import ohvp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               func,
    input  wire logic signed [31:0] image_x,
    input  wire logic signed [31:0] image_y,
    input  wire logic signed [31:0] catalog_x,
    input  wire logic signed [31:0] catalog_y,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output logic                    result_valid,
    output logic [7:0]              peak_bin_x,
    output logic [7:0]              peak_bin_y,
    output logic [15:0]             peak_votes,
    output logic signed [31:0]      shift_x,
    output logic signed [31:0]      shift_y
);
    localparam int BW    = $clog2(GRID);
    localparam int AW    = 2 * BW;
    localparam int CELLS = GRID * GRID;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DX   = 4'd2;
    localparam logic [3:0] S_DY   = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_WR   = 4'd5;
    localparam logic [3:0] S_SCAN = 4'd6;
    localparam logic [3:0] S_MX   = 4'd7;
    localparam logic [3:0] S_MY   = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;
    localparam logic [3:0] S_DXW  = 4'd10;
    localparam logic [3:0] S_DYW  = 4'd11;
    localparam logic [3:0] S_SL   = 4'd12;

    logic [3:0] st_reg, st_next;

    logic signed [31:0] xlo_reg, ylo_reg, xhi_reg, yhi_reg;

    // configuration writes are taken only while idle
    assign cfg_ready = (st_reg == S_IDLE);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xlo_reg <= 32'sd0; ylo_reg <= 32'sd0;
            xhi_reg <= 32'sd256; yhi_reg <= 32'sd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_XLO: xlo_reg <= cfg_data;
                REG_YLO: ylo_reg <= cfg_data;
                REG_XHI: xhi_reg <= cfg_data;
                REG_YHI: yhi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // histogram memory, one port each for read and write
    logic [CW-1:0] mem [CELLS];
    logic [AW-1:0] raddr, waddr;
    logic          we;
    logic [CW-1:0] wdata, rdata_reg;
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    // item registers
    logic signed [32:0] dx_reg, dy_reg;
    logic [BW-1:0]      bx_reg, by_reg;
    logic [3:0]         k_reg;
    logic [AW-1:0]      cnt_reg, best_i_reg;
    logic [CW-1:0]      best_reg;
    logic               scan_v_reg;
    logic [AW-1:0]      prev_reg;
    logic signed [63:0] prod_reg;
    logic               res_v_reg;
    logic [7:0]         obx_reg, oby_reg;
    logic [15:0]        ov_reg;
    logic signed [31:0] osx_reg, osy_reg;

    // shared divider
    logic          div_start, div_busy, div_done;
    logic [41:0]   dnum, dquo;
    logic [32:0]   dden;
    ohvp_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(dnum), .den(dden),
        .busy(div_busy), .done(div_done), .quo(dquo)
    );

    // numerator and range of the axis in work
    logic signed [33:0] diff;
    logic signed [33:0] rng;
    logic signed [43:0] numw;
    logic               ax_y;
    always_comb
    begin
        ax_y = (st_reg == S_DY) || (st_reg == S_DYW);
        diff = ax_y ? (34'(dy_reg) - 34'(ylo_reg)) : (34'(dx_reg) - 34'(xlo_reg));
        rng  = ax_y ? (34'(yhi_reg) - 34'(ylo_reg)) : (34'(xhi_reg) - 34'(xlo_reg));
        numw = 44'(diff) * 44'(GRID - 1);
        dnum = numw[41:0];
        dden = rng[32:0];
    end
    logic q_ok;
    assign q_ok = (dquo >= 42'd1) && (dquo <= 42'(GRID - 2));

    // kernel cell for step k
    logic [BW-1:0] kx, ky;
    logic [CW-1:0] kw;
    always_comb
    begin
        unique case (k_reg)
            4'd0: begin kx = bx_reg - 1'b1; ky = by_reg - 1'b1; kw = 16'd1; end
            4'd1: begin kx = bx_reg + 1'b1; ky = by_reg + 1'b1; kw = 16'd1; end
            4'd2: begin kx = bx_reg + 1'b1; ky = by_reg - 1'b1; kw = 16'd1; end
            4'd3: begin kx = bx_reg - 1'b1; ky = by_reg + 1'b1; kw = 16'd1; end
            4'd4: begin kx = bx_reg - 1'b1; ky = by_reg;        kw = 16'd4; end
            4'd5: begin kx = bx_reg;        ky = by_reg - 1'b1; kw = 16'd4; end
            4'd6: begin kx = bx_reg + 1'b1; ky = by_reg;        kw = 16'd4; end
            4'd7: begin kx = bx_reg;        ky = by_reg + 1'b1; kw = 16'd4; end
            default: begin kx = bx_reg;     ky = by_reg;        kw = 16'd10; end
        endcase
    end
    logic [CW:0] sum;
    assign sum = {1'b0, rdata_reg} + {1'b0, kw};

    // shift multiply operands
    logic signed [32:0] mrng;
    logic [BW-1:0]      mbin;
    logic signed [63:0] mfl;
    logic signed [64:0] msum;
    always_comb
    begin
        mrng = (st_reg == S_MY) ? (33'(yhi_reg) - 33'(ylo_reg))
                                : (33'(xhi_reg) - 33'(xlo_reg));
        mbin = (st_reg == S_MY) ? best_i_reg[AW-1:BW] : best_i_reg[BW-1:0];
        mfl  = prod_reg >>> BW;
        msum = 65'(mfl) + 65'((st_reg == S_SL) ? ylo_reg : xlo_reg);
    end
    logic signed [31:0] sat;
    always_comb
    begin
        if (msum > 65'sd2147483647)
            sat = 32'h7FFFFFFF;
        else if (msum < -65'sd2147483648)
            sat = 32'h80000000;
        else
            sat = msum[31:0];
    end

    // sequencer
    always_comb
    begin
        st_next = st_reg;
        div_start = 1'b0;
        we = 1'b0;
        waddr = cnt_reg;
        wdata = '0;
        raddr = cnt_reg;
        unique case (st_reg)
            S_CLR:
            begin
                we = 1'b1;
                if (cnt_reg == AW'(CELLS - 1))
                    st_next = S_IDLE;
            end
            S_IDLE:
                if (start)
                    st_next = (func == FUNC_REPORT) ? S_SCAN : S_DX;
            S_DX:
                if (rng <= 34'sd0 || diff < 34'sd0)
                    st_next = S_IDLE;
                else
                begin
                    div_start = 1'b1;
                    st_next = S_DXW;
                end
            S_DXW:
                if (div_done)
                    st_next = q_ok ? S_DY : S_IDLE;
            S_DY:
                if (rng <= 34'sd0 || diff < 34'sd0)
                    st_next = S_IDLE;
                else
                begin
                    div_start = 1'b1;
                    st_next = S_DYW;
                end
            S_DYW:
                if (div_done)
                    st_next = q_ok ? S_RD : S_IDLE;
            S_RD:
            begin
                raddr = {ky, kx};
                st_next = S_WR;
            end
            S_WR:
            begin
                we = 1'b1;
                waddr = {ky, kx};
                wdata = sum[CW] ? COUNT_MAX : sum[CW-1:0];
                st_next = (k_reg == 4'd8) ? S_IDLE : S_RD;
            end
            S_SCAN:
            begin
                we = scan_v_reg;
                waddr = prev_reg;
                if (scan_v_reg && prev_reg == AW'(CELLS - 1))
                    st_next = S_MX;
            end
            S_MX:   st_next = S_MY;
            S_MY:   st_next = S_SL;
            S_SL:   st_next = S_OUT;
            S_OUT:  st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_CLR;
            cnt_reg <= '0;
            res_v_reg <= 1'b0;
            scan_v_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            res_v_reg <= (st_reg == S_OUT);
            if (st_reg == S_CLR || st_reg == S_SCAN)
                cnt_reg <= cnt_reg + 1'b1;
            if (st_reg == S_IDLE)
                cnt_reg <= '0;
            scan_v_reg <= (st_reg == S_SCAN) && !(scan_v_reg && prev_reg == AW'(CELLS - 1));
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && start)
        begin
            dx_reg <= 33'(image_x) - 33'(catalog_x);
            dy_reg <= 33'(image_y) - 33'(catalog_y);
            k_reg <= 4'd0;
            best_reg <= '0;
            best_i_reg <= '0;
        end
        if (st_reg == S_DXW && div_done)
            bx_reg <= dquo[BW-1:0];
        if (st_reg == S_DYW && div_done)
            by_reg <= dquo[BW-1:0];
        if (st_reg == S_WR)
            k_reg <= k_reg + 4'd1;
        // scan: data of the previous address is ready now
        prev_reg <= cnt_reg;
        if (st_reg == S_SCAN && scan_v_reg && rdata_reg > best_reg)
        begin
            best_reg <= rdata_reg;
            best_i_reg <= prev_reg;
        end
        if (st_reg == S_MX || st_reg == S_MY)
            prod_reg <= 64'(mrng) * 64'($signed({1'b0, mbin}));
        if (st_reg == S_MY)
            osx_reg <= sat;
        if (st_reg == S_SL)
            osy_reg <= sat;
        if (st_reg == S_OUT)
        begin
            ov_reg  <= best_reg;
            if (best_reg == '0)
            begin
                obx_reg <= '0; oby_reg <= '0;
            end
            else
            begin
                obx_reg <= 8'(best_i_reg[BW-1:0]);
                oby_reg <= 8'(best_i_reg[AW-1:BW]);
            end
        end
    end

    assign busy         = (st_reg != S_IDLE);
    assign result_valid = res_v_reg;
    assign peak_bin_x   = obx_reg;
    assign peak_bin_y   = oby_reg;
    assign peak_votes   = ov_reg;
    assign shift_x      = (ov_reg == '0) ? 32'sd0 : osx_reg;
    assign shift_y      = (ov_reg == '0) ? 32'sd0 : osy_reg;

`include "offset_hough_vote_peak_assert.svh"
    `OHVP_ASSERT_NXT(a_res_idle, clk, rst_n, result_valid, !result_valid)
    `OHVP_ASSERT_IMP(a_res_busy, clk, rst_n, st_reg == S_SCAN, busy)
    `OHVP_ASSERT_IMP(a_div_once, clk, rst_n, div_start, !div_busy)
endmodule
`default_nettype wire
